>>> rtl/wds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_pkg
// Shared types and constants of the wildcard device ID search block.
// ----------------------------------------------------------------------------
package wds_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int ID_W     = 32;
  localparam int WIDX_W   = 8;
  localparam int ACT_W    = 9;
  localparam int CNT_W    = 9;
  localparam int STAT_W   = 2;
  localparam int NIBBLES  = ID_W / 4;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [CFG_AW-1:0] CFG_ADDR_ACTIVE = 3'd0;
  localparam logic [ACT_W-1:0]  ACTIVE_RESET    = 9'd255;
  localparam logic [CNT_W-1:0]  COUNT_MAX       = 9'd511;
  localparam logic [3:0]        NIB_WILD        = 4'hF;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_NONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ONE       = 2'd1;
  localparam logic [STAT_W-1:0] ST_COLLISION = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_POST
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_en;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic last;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/wds_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_ifs
// Valid/ready channel interfaces for requests and search results.
// ----------------------------------------------------------------------------
interface wds_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [wds_pkg::WIDX_W-1:0]  write_index;
  logic [wds_pkg::ID_W-1:0]    write_id;
  logic [wds_pkg::ID_W-1:0]    query_id;

  modport source (output valid, req_type, write_index, write_id, query_id, input ready);
  modport sink (input valid, req_type, write_index, write_id, query_id, output ready);
endinterface

interface wds_out_if;
  logic                        valid;
  logic                        ready;
  logic [wds_pkg::STAT_W-1:0]  search_status;
  logic [wds_pkg::CNT_W-1:0]   match_count;
  logic [wds_pkg::ID_W-1:0]    found_id;

  modport source (output valid, search_status, match_count, found_id, input ready);
  modport sink (input valid, search_status, match_count, found_id, output ready);
endinterface

>>> rtl/wds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_ctrl
// Controller that sequences loads, table scans and result transfers.
// ----------------------------------------------------------------------------
module wds_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_req_type,
  output logic               in_ready,
  input  wds_pkg::ctrl_sts_t sts,
  output wds_pkg::ctrl_cmd_t cmd
);

  wds_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wds_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wds_pkg::S_IDLE: begin
        if (accept && in_req_type == wds_pkg::REQ_SEARCH) begin
          state_nxt = sts.limit_zero ? wds_pkg::S_POST : wds_pkg::S_SCAN;
        end
      end
      wds_pkg::S_SCAN: begin
        if (sts.last) begin
          state_nxt = wds_pkg::S_FLUSH;
        end
      end
      wds_pkg::S_FLUSH: begin
        state_nxt = wds_pkg::S_POST;
      end
      wds_pkg::S_POST: begin
        if (sts.out_free) begin
          state_nxt = wds_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wds_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.start   = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.publish = 1'b0;
    unique case (state_r)
      wds_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && in_req_type == wds_pkg::REQ_LOAD;
        cmd.start = in_valid && in_req_type == wds_pkg::REQ_SEARCH;
      end
      wds_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      wds_pkg::S_FLUSH: begin
      end
      wds_pkg::S_POST: begin
        cmd.publish = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> sts.out_free)
    else $error("result published while the output register is occupied");

  a_flush_to_post: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wds_pkg::S_FLUSH |=> state_r == wds_pkg::S_POST)
    else $error("flush did not lead to result stage");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start, cmd.rd_en, cmd.publish}))
    else $error("conflicting datapath commands");

endmodule

>>> rtl/wds_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_dp
// Datapath: ID table memory, scan index, nibble compare, match counting and
// the result register.
// ----------------------------------------------------------------------------
module wds_dp #(
  parameter int TABLE_DEPTH = wds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wds_pkg::ACT_W-1:0]  active_entries,
  input  logic [wds_pkg::WIDX_W-1:0] write_index,
  input  logic [wds_pkg::ID_W-1:0]   write_id,
  input  logic [wds_pkg::ID_W-1:0]   query_id,
  input  wds_pkg::ctrl_cmd_t         cmd,
  output wds_pkg::ctrl_sts_t         sts,
  wds_out_if.source                  out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = (AW + 1 > wds_pkg::ACT_W) ? AW + 1 : wds_pkg::ACT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [wds_pkg::ID_W-1:0] mem [TABLE_DEPTH];

  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                limit;
  logic [CW-1:0]                act_ext;
  logic [CW-1:0]                widx_ext;
  logic                         wr_ok;
  logic [wds_pkg::ID_W-1:0]     query_r;
  logic [wds_pkg::ID_W-1:0]     rdata_r;
  logic                         rd_valid_r;
  logic                         match;
  logic [wds_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [wds_pkg::ID_W-1:0]     hit_r, hit_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [wds_pkg::STAT_W-1:0]   status_r;
  logic [wds_pkg::CNT_W-1:0]    out_count_r;
  logic [wds_pkg::ID_W-1:0]     found_r;

  assign act_ext  = CW'(active_entries);
  assign limit    = (act_ext > DEPTH_C) ? DEPTH_C : act_ext;
  assign widx_ext = CW'(write_index);
  assign wr_ok    = widx_ext < DEPTH_C;

  assign sts.limit_zero = limit == '0;
  assign sts.last       = idx_r == limit - CW'(1);
  assign sts.out_free   = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem[widx_ext[AW-1:0]] <= write_id;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int n = 0; n < wds_pkg::NIBBLES; n++) begin
      if (query_r[4*n +: 4] != wds_pkg::NIB_WILD && query_r[4*n +: 4] != rdata_r[4*n +: 4]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    count_nxt = count_r;
    hit_nxt   = hit_r;
    if (cmd.start) begin
      idx_nxt   = '0;
      count_nxt = '0;
    end else begin
      if (cmd.rd_en) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (rd_valid_r && match) begin
        if (count_r == '0) begin
          hit_nxt = rdata_r;
        end
        if (count_r != wds_pkg::COUNT_MAX) begin
          count_nxt = count_r + wds_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= cmd.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    count_r <= count_nxt;
    hit_r   <= hit_nxt;
    if (cmd.start) begin
      query_r <= query_id;
    end
    if (cmd.publish) begin
      out_count_r <= count_r;
      priority if (count_r == '0) begin
        status_r <= wds_pkg::ST_NONE;
        found_r  <= '0;
      end else if (count_r == wds_pkg::CNT_W'(1)) begin
        status_r <= wds_pkg::ST_ONE;
        found_r  <= hit_r;
      end else begin
        status_r <= wds_pkg::ST_COLLISION;
        found_r  <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.search_status = status_r;
  assign out_ch.match_count   = out_count_r;
  assign out_ch.found_id      = found_r;

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> idx_r < limit)
    else $error("table read beyond the active entries");

  a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_count_r == '0) == (status_r == wds_pkg::ST_NONE)))
    else $error("status disagrees with match count");

  a_found_only_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_r != '0 |-> status_r == wds_pkg::ST_ONE)
    else $error("nonzero ID reported without a unique match");

endmodule

>>> rtl/wildcard_device_id_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_device_id_search
// Table of device IDs searched with a nibble-wildcard pattern; reports the
// number of matches, a status and the unique matching ID.
// ----------------------------------------------------------------------------
// Port group   Direction  Role
// in_ch        sink       load one table entry or start a search
// out_ch       source     one search result per search transfer
// cfg_*        APB slave  active_entries register at byte address 0
//
// A load transfer is written to the table in its transfer cycle; the next
// request can follow in the next cycle.
// A search reads one table entry per cycle through the single memory read
// port over min(active_entries, TABLE_DEPTH) entries, then passes the flush
// and result states before its result is registered onto out_ch; with no
// active entry it skips the scan; it waits while a previous result is held.
// Loads are accepted while an earlier result waits on out_ch.
// Reset is synchronous, active low; the table contents are not cleared.
// ----------------------------------------------------------------------------
module wildcard_device_id_search #(
  parameter int TABLE_DEPTH = wds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wds_in_if.sink                     in_ch,
  wds_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [wds_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [wds_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [wds_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [wds_pkg::ACT_W-1:0] active_r, active_nxt;
  logic                      cfg_wr;
  wds_pkg::ctrl_cmd_t        cmd;
  wds_pkg::ctrl_sts_t        sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && cfg_paddr == wds_pkg::CFG_ADDR_ACTIVE;

  always_comb begin
    active_nxt = active_r;
    if (cfg_wr) begin
      active_nxt = cfg_pwdata[wds_pkg::ACT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= wds_pkg::ACTIVE_RESET;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr == wds_pkg::CFG_ADDR_ACTIVE)
                      ? wds_pkg::CFG_DW'(active_r) : '0;

  wds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  wds_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .active_entries (active_r),
    .write_index    (in_ch.write_index),
    .write_id       (in_ch.write_id),
    .query_id       (in_ch.query_id),
    .cmd            (cmd),
    .sts            (sts),
    .out_ch         (out_ch)
  );

endmodule
